// ===== hw/rtl/anb_pkg.sv =====
// Shared types and constants for the Annex B NAL splitter.
package anb_pkg;

  // Width of the stream position counter.
  localparam int unsigned OFFSET_BITS = 32;
  // Width used to saturate and truncate positions to the 32-bit result fields.
  localparam int unsigned WIDE_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 33;

  localparam logic [7:0] START_BYTE     = 8'h01;
  localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
  localparam logic [7:0] AUTO_MASK      = 8'h7E;
  localparam logic [5:0] H265_TYPE_MASK = 6'h3F;
  localparam logic [5:0] H264_IDR_TYPE  = 6'd5;
  localparam logic [5:0] H265_IDR_LO    = 6'd16;
  localparam logic [5:0] H265_IDR_HI    = 6'd21;

  typedef enum logic [1:0] {
    CODEC_AUTO = 2'd0,
    CODEC_H264 = 2'd1,
    CODEC_H265 = 2'd2
  } codec_mode_e;

  typedef struct packed {
    logic [5:0] nal_type;
    logic       is_idr;
    logic       codec_used;
  } hdr_info_t;

  typedef struct packed {
    logic [31:0] nal_offset;
    logic [31:0] nal_size;
    logic [5:0]  nal_type;
    logic        is_idr;
    logic        codec_used;
  } desc_t;

endpackage

// ===== hw/rtl/anb_if.sv =====
// Channel interfaces: configuration write, stream byte input, descriptor output.
interface anb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] codec_mode;

  modport source (output valid, output codec_mode, input ready);
  modport sink   (input valid, input codec_mode, output ready);
endinterface

interface anb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface anb_desc_if;
  logic        valid;
  logic        ready;
  logic [31:0] nal_offset;
  logic [31:0] nal_size;
  logic [5:0]  nal_type;
  logic        is_idr;
  logic        codec_used;

  modport source (output valid, output nal_offset, output nal_size, output nal_type,
                  output is_idr, output codec_used, input ready);
  modport sink   (input valid, input nal_offset, input nal_size, input nal_type,
                  input is_idr, input codec_used, output ready);
endinterface

// ===== hw/rtl/anb_hdr_decode.sv =====
// NAL header decode: codec choice, NAL type and IDR flag from the first payload byte.
module anb_hdr_decode import anb_pkg::*; (
  input  logic [7:0] hdr_i,
  input  logic [1:0] codec_mode_i,
  output hdr_info_t  info_o
);

  logic       h265;
  logic [5:0] nal_type;

  always_comb begin
    case (codec_mode_e'(codec_mode_i))
      CODEC_H264: h265 = 1'b0;
      CODEC_H265: h265 = 1'b1;
      default:    h265 = (hdr_i & AUTO_MASK) != 8'h00;
    endcase
  end

  always_comb begin
    if (h265) begin
      nal_type = hdr_i[6:1] & H265_TYPE_MASK;
      info_o.is_idr = (nal_type inside {[H265_IDR_LO:H265_IDR_HI]});
    end else begin
      nal_type = 6'(hdr_i & H264_TYPE_MASK);
      info_o.is_idr = (nal_type == H264_IDR_TYPE);
    end
    info_o.nal_type   = nal_type;
    info_o.codec_used = h265;
  end

endmodule

// ===== hw/rtl/anb_out_skid.sv =====
// Descriptor output register with one skid entry behind it.
module anb_out_skid import anb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output desc_t out_data_o
);

  logic  out_valid_q, skid_valid_q;
  desc_t out_data_q, skid_data_q;
  logic  pop;

  assign pop = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      // Output slot frees: refill from skid first, keep order.
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push_i;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_data_q  <= skid_data_q;
        skid_data_q <= push_data_i;
      end else begin
        out_data_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/annexb_nal_splitter_unit.sv =====
// Annex B start-code parser: splits a byte stream into NAL unit descriptors.
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  ------------------------------------------------
//   cfg_i    in   valid/ready    codec_mode (0 auto, 1 H.264, 2 H.265)
//   byte_i   in   valid/ready    data_byte, last_byte
//   desc_o   out  valid/ready    nal_offset, nal_size, nal_type, is_idr, codec_used
//
// One byte is taken per clock. A descriptor is registered into the output stage
// from the byte that closes its unit (the byte ending the next start code, or the
// byte marked last). The parser state updates in the same cycle a byte
// beat is taken; the critical path is the position subtract and compare feeding
// the descriptor size. Reset clears all parser state and sets codec_mode to auto;
// no clearing pass. A stalled output fills one skid entry; the byte input stalls
// only while both the output register and the skid entry hold descriptors.
module annexb_nal_splitter_unit import anb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  anb_cfg_if.sink    cfg_i,
  anb_byte_if.sink   byte_i,
  anb_desc_if.source desc_o
);

  localparam int unsigned POS_W = OFFSET_BITS;
  localparam logic [POS_W-1:0] PosMax = '1;

  // Configuration register.
  logic [1:0] codec_mode_q;

  // Parser state.
  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       zero_run_q, zero_run_d;
  logic             unit_open_q, unit_open_d;
  logic [POS_W-1:0] unit_start_q, unit_start_d;
  logic [7:0]       header_value_q, header_value_d;
  logic             header_pending_q, header_pending_d;

  logic             in_fire, in_ready;
  logic             is_start;
  logic [POS_W-1:0] pos_inc, back, code_begin, end_pos, size_full;
  logic [WIDE_W-1:0] size_wide, start_wide;
  logic [7:0]       hdr;
  logic             r_valid;
  hdr_info_t        hdr_info;
  desc_t            r_desc, out_desc;

  // Config port never stalls; writes must come only while idle, which the block itself does not enforce.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q <= CODEC_AUTO;
    end else if (cfg_i.valid) begin
      codec_mode_q <= cfg_i.codec_mode;
    end
  end

  assign byte_i.ready = in_ready;
  assign in_fire      = byte_i.valid && in_ready;

  // Position saturates at its maximum.
  assign pos_inc = (pos_q == PosMax) ? pos_q : pos_q + POS_W'(1);

  // Two or more zeros then 0x01 closes a start code.
  assign is_start = (byte_i.data_byte == START_BYTE) && zero_run_q[1];

  // A 4-byte code leaves any extra leading zeros with the previous unit.
  assign back       = (zero_run_q == 2'd3) ? POS_W'(3) : POS_W'(2);
  assign code_begin = (pos_q >= back) ? pos_q - back : '0;

  // Take the header from this byte if the open unit has not seen one yet.
  assign hdr = header_pending_q ? byte_i.data_byte : header_value_q;

  // A start code on the last byte counts as data: the unit ends after it.
  assign end_pos   = byte_i.last_byte ? pos_inc : code_begin;
  assign size_full = (end_pos > unit_start_q) ? end_pos - unit_start_q : '0;
  assign size_wide  = WIDE_W'(size_full);
  assign start_wide = WIDE_W'(unit_start_q);

  assign r_valid = in_fire && unit_open_q && (byte_i.last_byte || is_start);

  anb_hdr_decode u_hdr_decode (
    .hdr_i        (hdr),
    .codec_mode_i (codec_mode_q),
    .info_o       (hdr_info)
  );

  always_comb begin
    r_desc.nal_offset = start_wide[31:0];
    r_desc.nal_size   = (|size_wide[WIDE_W-1:32]) ? 32'hFFFF_FFFF : size_wide[31:0];
    r_desc.nal_type   = hdr_info.nal_type;
    r_desc.is_idr     = hdr_info.is_idr;
    r_desc.codec_used = hdr_info.codec_used;
  end

  always_comb begin
    pos_d            = pos_q;
    zero_run_d       = zero_run_q;
    unit_open_d      = unit_open_q;
    unit_start_d     = unit_start_q;
    header_value_d   = header_value_q;
    header_pending_d = header_pending_q;
    if (in_fire) begin
      header_value_d   = hdr;
      header_pending_d = 1'b0;
      pos_d            = pos_inc;
      if (byte_i.last_byte) begin
        // Close the stream: restart from offset zero.
        pos_d            = '0;
        zero_run_d       = 2'd0;
        unit_open_d      = 1'b0;
        unit_start_d     = '0;
        header_value_d   = 8'h00;
        header_pending_d = 1'b0;
      end else if (is_start) begin
        // Open a new unit; its header is the next byte.
        unit_open_d      = 1'b1;
        unit_start_d     = pos_inc;
        header_value_d   = 8'h00;
        header_pending_d = 1'b1;
        zero_run_d       = 2'd0;
      end else if (byte_i.data_byte == 8'h00) begin
        if (zero_run_q != 2'd3) begin
          zero_run_d = zero_run_q + 2'd1;
        end
      end else begin
        zero_run_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q            <= '0;
      zero_run_q       <= 2'd0;
      unit_open_q      <= 1'b0;
      unit_start_q     <= '0;
      header_value_q   <= 8'h00;
      header_pending_q <= 1'b0;
    end else begin
      pos_q            <= pos_d;
      zero_run_q       <= zero_run_d;
      unit_open_q      <= unit_open_d;
      unit_start_q     <= unit_start_d;
      header_value_q   <= header_value_d;
      header_pending_q <= header_pending_d;
    end
  end

  anb_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (r_valid),
    .push_data_i (r_desc),
    .ready_o     (in_ready),
    .out_valid_o (desc_o.valid),
    .out_ready_i (desc_o.ready),
    .out_data_o  (out_desc)
  );

  assign desc_o.nal_offset = out_desc.nal_offset;
  assign desc_o.nal_size   = out_desc.nal_size;
  assign desc_o.nal_type   = out_desc.nal_type;
  assign desc_o.is_idr     = out_desc.is_idr;
  assign desc_o.codec_used = out_desc.codec_used;

  // A pending header only exists inside an open unit.
  a_pending_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    header_pending_q |-> unit_open_q)
    else $error("header pending with no unit open");

  // The last byte restarts the parser at offset zero.
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && byte_i.last_byte) |=> (!unit_open_q && pos_q == '0 && zero_run_q == 2'd0))
    else $error("parser not restarted after last byte");

  // A start code inside the stream arms the header capture.
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_start && !byte_i.last_byte) |=> (header_pending_q && unit_open_q))
    else $error("start code did not open a unit");

  // A descriptor is never pushed while the skid entry is occupied.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid |-> in_ready)
    else $error("descriptor pushed into full output stage");

endmodule

// ===== sim/annexb_nal_splitter_unit_tb.sv =====
// Self-checking testbench for the Annex B NAL splitter unit.
`timescale 1ns / 100ps

module annexb_nal_splitter_unit_tb;
  import anb_pkg::*;

  // Register value the codec enum leaves unnamed; the block reads it as auto.
  localparam logic [1:0] CODEC_RSVD = 2'd3;

  // Highest stream position; the counter holds there instead of wrapping.
  localparam logic [63:0] POS_LIMIT =
      (OFFSET_BITS >= 64) ? '1 : ((64'd1 << OFFSET_BITS) - 64'd1);

  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 4;     // quiet time before a register write
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no beat at all

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  anb_cfg_if  cfg_ch ();
  anb_byte_if byte_ch ();
  anb_desc_if desc_ch ();

  annexb_nal_splitter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .byte_i (byte_ch),
    .desc_o (desc_ch)
  );

  // Parser mirror: register copy plus the scan state, all starting at their reset values.
  logic [1:0]  codec_cfg = CODEC_AUTO;
  logic [63:0] scan_pos  = '0;
  logic [1:0]  zero_cnt  = '0;
  bit          nal_open  = 1'b0;
  logic [63:0] nal_begin = '0;
  logic [7:0]  nal_hdr   = '0;
  bit          hdr_due   = 1'b0;

  desc_t       nal_q [$];       // descriptors still owed by the block
  int unsigned fail_count    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_idle_pct  = 0;
  int unsigned hold_requests = 0;

  // Build the descriptor of the open unit, ending just before stop.
  function automatic desc_t close_unit(input logic [63:0] stop);
    desc_t       d;
    logic [63:0] span;
    bit          h265;
    logic [5:0]  kind;
    span = (stop > nal_begin) ? stop - nal_begin : 64'd0;
    if (codec_cfg == CODEC_H264) begin
      h265 = 1'b0;
    end else if (codec_cfg == CODEC_H265) begin
      h265 = 1'b1;
    end else begin
      h265 = (nal_hdr & AUTO_MASK) != 8'd0;
    end
    if (h265) begin
      kind      = nal_hdr[6:1] & H265_TYPE_MASK;
      d.is_idr  = (kind >= H265_IDR_LO) && (kind <= H265_IDR_HI);
    end else begin
      kind      = 6'(nal_hdr & H264_TYPE_MASK);
      d.is_idr  = (kind == H264_IDR_TYPE);
    end
    d.nal_offset = nal_begin[31:0];
    d.nal_size   = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    d.nal_type   = kind;
    d.codec_used = h265;
    return d;
  endfunction

  // Advance the mirror by one stream byte; returns 1 when a unit closes.
  function automatic bit scan_byte(input logic [7:0] value, input logic is_last,
                                   output desc_t d);
    logic [63:0] here;
    logic [63:0] back;
    bit          closed;
    closed = 1'b0;
    d      = '0;
    here   = scan_pos;
    // The first payload byte becomes the header, even if it is the last byte.
    if (hdr_due) begin
      nal_hdr = value;
      hdr_due = 1'b0;
    end
    if (is_last) begin
      // A start code finishing here is plain data of the open unit.
      if (nal_open) begin
        d      = close_unit((here < POS_LIMIT) ? here + 64'd1 : POS_LIMIT);
        closed = 1'b1;
      end
      scan_pos  = '0;
      zero_cnt  = '0;
      nal_open  = 1'b0;
      nal_begin = '0;
      nal_hdr   = '0;
      hdr_due   = 1'b0;
      return closed;
    end
    if (value == START_BYTE && zero_cnt >= 2'd2) begin
      // Zeros beyond the 4-byte form remain in the previous unit.
      back = (zero_cnt == 2'd3) ? 64'd3 : 64'd2;
      if (nal_open) begin
        d      = close_unit((here >= back) ? here - back : 64'd0);
        closed = 1'b1;
      end
      nal_open  = 1'b1;
      nal_begin = (here < POS_LIMIT) ? here + 64'd1 : POS_LIMIT;
      nal_hdr   = '0;
      hdr_due   = 1'b1;
      zero_cnt  = '0;
    end else if (value == 8'h00) begin
      if (zero_cnt != 2'd3) zero_cnt = zero_cnt + 2'd1;
    end else begin
      zero_cnt = '0;
    end
    if (here < POS_LIMIT) scan_pos = here + 64'd1;
    return closed;
  endfunction

  // Zero-heavy byte mix so start codes show up inside payloads and noise.
  function automatic logic [7:0] noise_byte();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3) return 8'h00;
    if (pick == 3) return START_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // Headers that hit both codecs, IDR and non-IDR, and the auto split.
  function automatic logic [7:0] pick_header();
    logic [7:0] pool [8] = '{8'h65, 8'h41, 8'h05, 8'h00, 8'h81, 8'h26, 8'h20, 8'h2C};
    if ($urandom_range(1) == 0) return pool[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  // Offer one byte beat, idling first at the sender's rate; predict on accept.
  task automatic push_byte(input logic [7:0] value, input logic is_last = 1'b0);
    desc_t d;
    if ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= value;
    byte_ch.last_byte <= is_last;
    do @(posedge clk_i); while (!byte_ch.ready);
    if (scan_byte(value, is_last, d)) nal_q.push_back(d);
    bytes_sent++;
  endtask

  // Drop valid and hold until every owed descriptor is back, then settle.
  task automatic wait_results_done();
    byte_ch.valid <= 1'b0;
    while (nal_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the codec register; only called with the block idle.
  task automatic write_codec(input logic [1:0] mode);
    wait_results_done();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.codec_mode <= mode;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    codec_cfg = mode;
  endtask

  // One stream: optional junk, start-coded units, and a closing last byte.
  task automatic send_stream(input int unsigned units, input int unsigned max_len);
    int unsigned len;
    int unsigned zeros;
    int unsigned ending;
    repeat ($urandom_range(3)) push_byte(noise_byte());
    for (int unsigned u = 0; u < units; u++) begin
      // 3-byte form, 4-byte form, or 4-byte form with excess zeros
      zeros = $urandom_range(3);
      zeros = (zeros == 0) ? 2 : (zeros == 3) ? 4 + $urandom_range(1) : 3;
      repeat (zeros) push_byte(8'h00);
      push_byte(START_BYTE);
      len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, max_len);
      if (len != 0) begin
        push_byte(pick_header());
        repeat (len - 1) push_byte(noise_byte());
      end
    end
    ending = $urandom_range(9);
    if (ending == 0) begin
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(START_BYTE, 1'b1);
    end else begin
      push_byte((ending == 1) ? 8'h00 : 8'($urandom_range(255)), 1'b1);
    end
  endtask

  // Fixed sequence: last byte with nothing open, 4-byte and 3-byte codes,
  // an empty unit, excess zeros, and a start code landing on the last byte.
  task automatic test_directed();
    src_idle_pct = 27;
    snk_idle_pct = 62;
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(START_BYTE);
    push_byte(8'h65);
    push_byte(8'h00); push_byte(8'h00); push_byte(START_BYTE);
    push_byte(8'h00); push_byte(8'h00); push_byte(START_BYTE);
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
    push_byte(START_BYTE);
    push_byte(8'h2A); push_byte(8'hFF);
    push_byte(8'h00); push_byte(8'h00); push_byte(START_BYTE, 1'b1);
  endtask

  // Walk every register value, including the unused code, over short streams.
  task automatic test_codec_modes();
    logic [1:0] modes [4] = '{CODEC_H264, CODEC_H265, CODEC_RSVD, CODEC_AUTO};
    foreach (modes[i]) begin
      write_codec(modes[i]);
      repeat (3) send_stream(4, 6);
    end
  endtask

  // Mostly well-formed streams with random content, some pure noise;
  // change the codec now and then between streams.
  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned goal);
    int unsigned stop_at;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = bytes_sent + goal;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(5) == 0) write_codec(2'($urandom_range(3)));
      send_stream(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6),
                  ($urandom_range(15) == 0) ? 48 : 10);
    end
  endtask

  // Hold the receiver off while tiny units keep coming so the block backs up,
  // then pause the sender until the backlog is gone.
  task automatic test_backpressure();
    wait_results_done();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_requests++;
    repeat (2) send_stream(20, 2);
    wait_results_done();
  endtask

  // Receiver: random ready, plus a long hold-off counted here when requested.
  initial begin : desc_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    desc_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        desc_ch.ready <= 1'b0;
      end else begin
        desc_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Compare each descriptor beat with the oldest one owed.
  always @(posedge clk_i) begin : desc_check
    desc_t want;
    if (rst_ni && desc_ch.valid && desc_ch.ready) begin
      if (nal_q.size() == 0) begin
        $error("unexpected descriptor: nal_offset %0d nal_size %0d nal_type %0d",
               desc_ch.nal_offset, desc_ch.nal_size, desc_ch.nal_type);
        fail_count++;
      end else begin
        want = nal_q.pop_front();
        if (desc_ch.nal_offset !== want.nal_offset) begin
          $error("nal_offset: expected %0d, got %0d", want.nal_offset, desc_ch.nal_offset);
          fail_count++;
        end
        if (desc_ch.nal_size !== want.nal_size) begin
          $error("nal_size: expected %0d, got %0d", want.nal_size, desc_ch.nal_size);
          fail_count++;
        end
        if (desc_ch.nal_type !== want.nal_type) begin
          $error("nal_type: expected %0d, got %0d", want.nal_type, desc_ch.nal_type);
          fail_count++;
        end
        if (desc_ch.is_idr !== want.is_idr) begin
          $error("is_idr: expected %0b, got %0b", want.is_idr, desc_ch.is_idr);
          fail_count++;
        end
        if (desc_ch.codec_used !== want.codec_used) begin
          $error("codec_used: expected %0b, got %0b", want.codec_used, desc_ch.codec_used);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run once no channel has moved a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((cfg_ch.valid && cfg_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
          (desc_ch.valid && desc_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no beat for %0d cycles, %0d descriptors outstanding", QUIET_LIMIT, nal_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run
    rst_ni            <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.codec_mode <= CODEC_AUTO;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_codec_modes();
    test_random_traffic(27, 62, 360);
    test_random_traffic(62, 27, 360);
    test_random_traffic(0, 0, 360);
    test_backpressure();

    // Wait until everything owed has arrived, then keep watching for stray beats.
    wait_results_done();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/anb_pkg.sv
hw/rtl/anb_if.sv
hw/rtl/anb_hdr_decode.sv
hw/rtl/anb_out_skid.sv
hw/rtl/annexb_nal_splitter_unit.sv
sim/annexb_nal_splitter_unit_tb.sv
